FILE: design/pse_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pse_pkg
// shared types and constants of the perceptron score and update engine
// ----------------------------------------------------------------------------
package pse_pkg;

    localparam int FEATURES = 1024;
    localparam int ADDR_W   = (FEATURES > 1) ? $clog2(FEATURES) : 1;
    localparam int FEAT_W   = 16;
    localparam int WGT_W    = 32;
    localparam int ACC_W    = 48;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW  = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW  = FIFO_AW + 1;

    typedef enum logic [0:0] {
        OP_SCORE  = 1'b0,
        OP_UPDATE = 1'b1
    } t_op;

    typedef logic [ADDR_W-1:0]        t_addr;
    typedef logic signed [FEAT_W-1:0] t_feat;
    typedef logic signed [WGT_W-1:0]  t_wgt;
    typedef logic signed [ACC_W-1:0]  t_acc;

endpackage

FILE: design/pse_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pse_in_if / pse_out_if
// valid-ready channels for input elements and score results
// ----------------------------------------------------------------------------
interface pse_in_if;
    logic           valid;
    logic           ready;
    pse_pkg::t_op   op;
    pse_pkg::t_feat feature;
    pse_pkg::t_feat change;
    logic           last;

    modport source (output valid, op, feature, change, last, input ready);
    modport sink   (input valid, op, feature, change, last, output ready);
endinterface

interface pse_out_if;
    logic          valid;
    logic          ready;
    pse_pkg::t_acc score;

    modport source (output valid, score, input ready);
    modport sink   (input valid, score, output ready);
endinterface

FILE: design/perceptron_score_update_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// perceptron_score_update_engine
// streaming perceptron scoring and weight update over a dense weight memory
// ----------------------------------------------------------------------------
// One element beat is accepted per cycle. The position in the vector is
// counted internally and returns to zero after a beat marked last. A score
// beat multiplies the weight by the feature and adds it into a saturating
// Q12.36 accumulator; a score beat marked last yields one result beat, taken
// from the stage 2 sum. An update beat adds change times feature to the
// weight, saturating at Q8.24. The weight memory has one read and one write
// port; back-to-back accesses to the same weight are forwarded. After reset
// a clearing pass zeroes all FEATURES (1024) weights, during which no beat
// is accepted. A four-entry result buffer absorbs backpressure; otherwise
// the input stalls only when that buffer plus results in flight are full.
// ----------------------------------------------------------------------------
module perceptron_score_update_engine (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pse_in_if.sink    i_item,
    pse_out_if.source o_result
);

    localparam pse_pkg::t_addr LAST_ADDR = pse_pkg::ADDR_W'(pse_pkg::FEATURES - 1);

    pse_pkg::t_wgt r_mem [pse_pkg::FEATURES];

    logic           r_clr_act;
    pse_pkg::t_addr r_clr_idx;
    pse_pkg::t_addr r_pos;

    logic           r_s1_vld;
    pse_pkg::t_op   r_s1_op;
    pse_pkg::t_feat r_s1_feat;
    pse_pkg::t_feat r_s1_chg;
    logic           r_s1_last;
    pse_pkg::t_addr r_s1_idx;
    pse_pkg::t_wgt  r_s1_rdata;

    logic           r_byp_vld;
    pse_pkg::t_addr r_byp_idx;
    pse_pkg::t_wgt  r_byp_data;

    logic           r_s2_vld;
    pse_pkg::t_op   r_s2_op;
    logic           r_s2_last;
    pse_pkg::t_acc  r_s2_prod;

    pse_pkg::t_acc  r_acc;

    pse_pkg::t_acc                r_fifo [pse_pkg::FIFO_DEPTH];
    logic [pse_pkg::FIFO_AW-1:0]  r_wptr;
    logic [pse_pkg::FIFO_AW-1:0]  r_rptr;
    logic [pse_pkg::FIFO_CW-1:0]  r_cnt;

    logic                         accept;
    logic                         pop;
    logic                         push;
    logic                         s1_res;
    logic                         s2_res;
    logic [pse_pkg::FIFO_CW:0]    pending;
    pse_pkg::t_wgt                w_cur;
    logic signed [pse_pkg::WGT_W-1:0] prod_u;
    logic signed [pse_pkg::WGT_W:0]   wsum;
    pse_pkg::t_wgt                n_wnew;
    pse_pkg::t_acc                n_prod;
    logic signed [pse_pkg::ACC_W:0]   asum;
    pse_pkg::t_acc                n_acc;

    // credit check against the result buffer
    assign s1_res  = r_s1_vld && (r_s1_op == pse_pkg::OP_SCORE) && r_s1_last;
    assign s2_res  = r_s2_vld && (r_s2_op == pse_pkg::OP_SCORE) && r_s2_last;
    assign pending = (pse_pkg::FIFO_CW+1)'(r_cnt) + (pse_pkg::FIFO_CW+1)'(s1_res)
                   + (pse_pkg::FIFO_CW+1)'(s2_res);

    assign i_item.ready = !r_clr_act
                       && (pending < (pse_pkg::FIFO_CW+1)'(pse_pkg::FIFO_DEPTH));
    assign accept       = i_item.valid && i_item.ready;

    // stage 1: forward, update weight, score product
    assign w_cur  = (r_byp_vld && (r_byp_idx == r_s1_idx)) ? r_byp_data : r_s1_rdata;
    assign prod_u = pse_pkg::WGT_W'(r_s1_chg) * pse_pkg::WGT_W'(r_s1_feat);
    assign wsum   = (pse_pkg::WGT_W+1)'(w_cur) + (pse_pkg::WGT_W+1)'(prod_u);

    always_comb begin
        if (wsum[pse_pkg::WGT_W] != wsum[pse_pkg::WGT_W-1]) begin
            n_wnew = wsum[pse_pkg::WGT_W] ? {1'b1, {(pse_pkg::WGT_W-1){1'b0}}}
                                          : {1'b0, {(pse_pkg::WGT_W-1){1'b1}}};
        end else begin
            n_wnew = wsum[pse_pkg::WGT_W-1:0];
        end
    end

    assign n_prod = pse_pkg::ACC_W'(r_s1_feat) * pse_pkg::ACC_W'(w_cur);

    // stage 2: saturating accumulate
    assign asum = (pse_pkg::ACC_W+1)'(r_acc) + (pse_pkg::ACC_W+1)'(r_s2_prod);

    always_comb begin
        if (asum[pse_pkg::ACC_W] != asum[pse_pkg::ACC_W-1]) begin
            n_acc = asum[pse_pkg::ACC_W] ? {1'b1, {(pse_pkg::ACC_W-1){1'b0}}}
                                         : {1'b0, {(pse_pkg::ACC_W-1){1'b1}}};
        end else begin
            n_acc = asum[pse_pkg::ACC_W-1:0];
        end
    end

    assign push = s2_res;
    assign pop  = o_result.valid && o_result.ready;

    assign o_result.valid = (r_cnt != '0);
    assign o_result.score = r_fifo[r_rptr];

    // weight memory
    always_ff @(posedge i_clk) begin
        if (r_clr_act) begin
            r_mem[r_clr_idx] <= '0;
        end else if (r_s1_vld && (r_s1_op == pse_pkg::OP_UPDATE)) begin
            r_mem[r_s1_idx] <= n_wnew;
        end
        if (accept) begin
            r_s1_rdata <= r_mem[r_pos];
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_op   <= i_item.op;
            r_s1_feat <= i_item.feature;
            r_s1_chg  <= i_item.change;
            r_s1_last <= i_item.last;
            r_s1_idx  <= r_pos;
        end
        r_byp_idx  <= r_s1_idx;
        r_byp_data <= n_wnew;
        r_s2_op    <= r_s1_op;
        r_s2_last  <= r_s1_last;
        r_s2_prod  <= n_prod;
        if (push) begin
            r_fifo[r_wptr] <= n_acc;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_act <= 1'b1;
            r_clr_idx <= '0;
            r_pos     <= '0;
            r_s1_vld  <= 1'b0;
            r_byp_vld <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_acc     <= '0;
            r_wptr    <= '0;
            r_rptr    <= '0;
            r_cnt     <= '0;
        end else begin
            if (r_clr_act) begin
                r_clr_idx <= r_clr_idx + 1'b1;
                if (r_clr_idx == LAST_ADDR) begin
                    r_clr_act <= 1'b0;
                end
            end
            if (accept) begin
                if (i_item.last || (r_pos == LAST_ADDR)) begin
                    r_pos <= '0;
                end else begin
                    r_pos <= r_pos + 1'b1;
                end
            end
            r_s1_vld  <= accept;
            r_byp_vld <= r_s1_vld && (r_s1_op == pse_pkg::OP_UPDATE);
            r_s2_vld  <= r_s1_vld;
            if (r_s2_vld) begin
                if (r_s2_last) begin
                    r_acc <= '0;
                end else if (r_s2_op == pse_pkg::OP_SCORE) begin
                    r_acc <= n_acc;
                end
            end
            if (push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            r_cnt <= r_cnt + pse_pkg::FIFO_CW'(push) - pse_pkg::FIFO_CW'(pop);
        end
    end

endmodule

FILE: design/pse_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pse_checker
// port-level checks of the perceptron score and update engine
// ----------------------------------------------------------------------------
module pse_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                i_in_ready,
    input pse_pkg::t_op        i_in_op,
    input logic                i_in_last,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input pse_pkg::t_acc       i_out_score
);

    logic score_end;

    assign score_end = i_in_valid && i_in_ready && (i_in_op == pse_pkg::OP_SCORE) && i_in_last;

    // clearing pass blocks input right after reset
    a_clear_blocks: assert property (@(posedge i_clk) !i_rst_n |=> !i_in_ready)
        else $error("input ready during weight clearing");

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result beat right after reset");

    // an accepted score beat marked last is followed by a valid result beat
    a_result_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        score_end |-> ##3 i_out_valid)
        else $error("missing score result");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_score))
        else $error("stalled result beat changed");

endmodule

bind perceptron_score_update_engine pse_checker u_pse_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_item.valid),
    .i_in_ready  (i_item.ready),
    .i_in_op     (i_item.op),
    .i_in_last   (i_item.last),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_out_score (o_result.score)
);

FILE: tb/perceptron_score_update_engine_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// perceptron_score_update_engine_tb
// self-checking bench: a queue-fed element driver, a score monitor and a
// per-beat model of the weight store, the position counter and the
// saturating accumulator; covers directed extremes, random update and score
// vectors under several handshake mixes, a long receiver hold and a vector
// that runs past FEATURES
// ----------------------------------------------------------------------------
module perceptron_score_update_engine_tb;

    localparam int     CYCLE_LIMIT  = 400000;
    localparam int     DRAIN_CYCLES = 12;
    localparam int     HOLD_CYCLES  = 400;
    localparam int     PHASE_ITEMS  = 30;
    localparam int     HOLD_ITEMS   = 50;
    localparam int     WRAP_EXTRA   = 5;
    localparam longint ACC_MAX      = (longint'(1) <<< (pse_pkg::ACC_W - 1)) - 1;
    localparam longint ACC_MIN      = -ACC_MAX - 1;
    localparam longint WGT_MAX      = (longint'(1) <<< (pse_pkg::WGT_W - 1)) - 1;
    localparam longint WGT_MIN      = -WGT_MAX - 1;

    typedef struct {
        pse_pkg::t_op   op;
        pse_pkg::t_feat feature;
        pse_pkg::t_feat change;
        logic           last;
    } t_elem;

    typedef enum int {
        VEC_SCORE,
        VEC_UPDATE,
        VEC_MIXED
    } t_vec_kind;

    logic i_clk;
    logic i_rst_n;

    pse_in_if  item_if ();
    pse_out_if result_if ();

    perceptron_score_update_engine dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_if),
        .o_result (result_if)
    );

    t_elem          pending_elems [$];
    pse_pkg::t_acc  expected_scores [$];

    // model state
    pse_pkg::t_wgt  weight_mem [pse_pkg::FEATURES];
    int     vec_pos;
    longint running_sum;

    int     src_idle_pct;
    int     sink_stall_pct;
    int     hold_token;
    int     hold_seen;
    int     hold_left;
    int     cycle_count;
    int     fail_count;
    int     beats_taken;
    int     scores_checked;

    function automatic void predict_element(input t_elem e);
        longint prod;
        longint sum;
        if (e.op == pse_pkg::OP_SCORE) begin
            prod = longint'(e.feature) * longint'(weight_mem[vec_pos]);
            sum  = running_sum + prod;
            running_sum = (sum > ACC_MAX) ? ACC_MAX : (sum < ACC_MIN) ? ACC_MIN : sum;
            if (e.last) begin
                expected_scores.push_back(pse_pkg::t_acc'(running_sum));
            end
        end else begin
            sum = longint'(weight_mem[vec_pos]) + longint'(e.change) * longint'(e.feature);
            weight_mem[vec_pos] = pse_pkg::t_wgt'((sum > WGT_MAX) ? WGT_MAX :
                                                  (sum < WGT_MIN) ? WGT_MIN : sum);
        end
        if (e.last) begin
            vec_pos     = 0;
            running_sum = 0;
        end else begin
            vec_pos = (vec_pos + 1) % pse_pkg::FEATURES;
        end
    endfunction

    function automatic pse_pkg::t_feat rand_q412();
        if ($urandom_range(1) == 0) begin
            return pse_pkg::t_feat'($urandom);
        end
        return pse_pkg::t_feat'(int'($urandom_range(2047)) - 1024);
    endfunction

    // clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("perceptron_score_update_engine_tb: FAIL");
            $finish;
        end
    end

    // element driver
    always @(posedge i_clk) begin
        t_elem nxt;
        if (!i_rst_n) begin
            item_if.valid   <= 1'b0;
            item_if.op      <= pse_pkg::OP_SCORE;
            item_if.feature <= '0;
            item_if.change  <= '0;
            item_if.last    <= 1'b0;
        end else begin
            if (item_if.valid && item_if.ready) begin
                nxt.op      = item_if.op;
                nxt.feature = item_if.feature;
                nxt.change  = item_if.change;
                nxt.last    = item_if.last;
                predict_element(nxt);
                beats_taken <= beats_taken + 1;
            end
            if (!item_if.valid || item_if.ready) begin
                if (pending_elems.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                    nxt = pending_elems.pop_front();
                    item_if.valid   <= 1'b1;
                    item_if.op      <= nxt.op;
                    item_if.feature <= nxt.feature;
                    item_if.change  <= nxt.change;
                    item_if.last    <= nxt.last;
                end else begin
                    item_if.valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_seen <= 0;
        end else if (hold_token != hold_seen) begin
            hold_seen <= hold_token;
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // score monitor
    always @(posedge i_clk) begin
        pse_pkg::t_acc want;
        if (!i_rst_n) begin
            result_if.ready <= 1'b0;
        end else begin
            if (result_if.valid && result_if.ready) begin
                scores_checked <= scores_checked + 1;
                if (expected_scores.size() == 0) begin
                    $display("%0t: unexpected score beat, expected none got %0d",
                             $time, result_if.score);
                    fail_count <= fail_count + 1;
                end else begin
                    want = expected_scores.pop_front();
                    if (result_if.score !== want) begin
                        $display("%0t: score mismatch, expected %0d got %0d",
                                 $time, want, result_if.score);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            result_if.ready <= (hold_left == 0) && ($urandom_range(99) >= sink_stall_pct);
        end
    end

    task automatic push_elem(input pse_pkg::t_op op, input int feature, input int change,
                             input logic last);
        t_elem e;
        e.op      = op;
        e.feature = pse_pkg::t_feat'(feature);
        e.change  = pse_pkg::t_feat'(change);
        e.last    = last;
        pending_elems.push_back(e);
    endtask

    task automatic queue_vector(input int len, input t_vec_kind kind);
        t_elem e;
        for (int k = 0; k < len; k++) begin
            case (kind)
                VEC_SCORE:  e.op = pse_pkg::OP_SCORE;
                VEC_UPDATE: e.op = pse_pkg::OP_UPDATE;
                default:    e.op = pse_pkg::t_op'($urandom_range(1));
            endcase
            e.feature = rand_q412();
            e.change  = rand_q412();
            e.last    = (k == len - 1);
            pending_elems.push_back(e);
        end
    endtask

    task automatic wait_idle();
        while (pending_elems.size() != 0 || item_if.valid || expected_scores.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic run_random(input int n_items, input int src_pct, input int sink_pct);
        int        queued;
        int        len;
        int        pick;
        t_vec_kind kind;
        @(negedge i_clk);
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        queued = 0;
        while (queued < n_items) begin
            pick = $urandom_range(99);
            kind = (pick < 40) ? VEC_UPDATE : (pick < 85) ? VEC_SCORE : VEC_MIXED;
            len  = ($urandom_range(4) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
            queue_vector(len, kind);
            queued += len;
        end
        wait_idle();
    endtask

    initial begin
        i_rst_n         = 1'b0;
        item_if.valid   = 1'b0;
        item_if.op      = pse_pkg::OP_SCORE;
        item_if.feature = '0;
        item_if.change  = '0;
        item_if.last    = 1'b0;
        result_if.ready = 1'b0;
        src_idle_pct    = 0;
        sink_stall_pct  = 0;
        hold_token      = 0;
        cycle_count     = 0;
        fail_count      = 0;
        beats_taken     = 0;
        scores_checked  = 0;
        vec_pos         = 0;
        running_sum     = 0;
        foreach (weight_mem[i]) weight_mem[i] = '0;

        // cleared store scores zero
        push_elem(pse_pkg::OP_SCORE, 32767, 0, 1'b1);
        push_elem(pse_pkg::OP_SCORE, -32768, 32767, 1'b0);
        push_elem(pse_pkg::OP_SCORE, 0, -32768, 1'b1);
        // largest positive steps, update vector ending in last
        push_elem(pse_pkg::OP_UPDATE, -32768, -32768, 1'b0);
        push_elem(pse_pkg::OP_UPDATE, -32768, -32768, 1'b0);
        push_elem(pse_pkg::OP_UPDATE, -32768, -32768, 1'b1);
        // weights 0 and 1 clamp at the top
        push_elem(pse_pkg::OP_UPDATE, -32768, -32768, 1'b0);
        push_elem(pse_pkg::OP_UPDATE, -32768, -32768, 1'b0);
        push_elem(pse_pkg::OP_UPDATE, 32767, 32767, 1'b1);
        // accumulator clamps high then low
        push_elem(pse_pkg::OP_SCORE, 32767, 0, 1'b0);
        push_elem(pse_pkg::OP_SCORE, 32767, 0, 1'b0);
        push_elem(pse_pkg::OP_SCORE, 32767, 0, 1'b1);
        push_elem(pse_pkg::OP_SCORE, -32768, 0, 1'b0);
        push_elem(pse_pkg::OP_SCORE, -32768, 0, 1'b0);
        push_elem(pse_pkg::OP_SCORE, -32768, 0, 1'b1);
        // update marked last drops the partial score
        push_elem(pse_pkg::OP_SCORE, 1, 0, 1'b0);
        push_elem(pse_pkg::OP_UPDATE, 32767, -32768, 1'b1);
        push_elem(pse_pkg::OP_SCORE, 1, 0, 1'b0);
        push_elem(pse_pkg::OP_SCORE, -1, 0, 1'b1);

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        wait_idle();

        run_random(PHASE_ITEMS, 0, 0);
        run_random(PHASE_ITEMS, 75, 0);
        run_random(PHASE_ITEMS, 0, 75);
        run_random(PHASE_ITEMS, 24, 24);

        // results pile up behind the held receiver until the input stalls
        @(negedge i_clk);
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        hold_token     = hold_token + 1;
        for (int k = 0; k < HOLD_ITEMS; k++) begin
            queue_vector(1, ($urandom_range(5) == 0) ? VEC_UPDATE : VEC_SCORE);
        end
        wait_idle();

        // one vector past FEATURES wraps back onto the low weights
        @(negedge i_clk);
        sink_stall_pct = 10;
        queue_vector(pse_pkg::FEATURES + WRAP_EXTRA, VEC_SCORE);
        wait_idle();

        $display("covered: directed clamps, four handshake mixes, a %0d-cycle hold, a wrap",
                 HOLD_CYCLES);
        $display("%0d element beats accepted, %0d score beats checked, %0d mismatches",
                 beats_taken, scores_checked, fail_count);
        if (fail_count == 0) begin
            $display("perceptron_score_update_engine_tb: PASS");
        end else begin
            $display("perceptron_score_update_engine_tb: FAIL");
        end
        $finish;
    end

endmodule

FILE: perceptron_score_update_engine.f
design/pse_pkg.sv
design/pse_if.sv
design/perceptron_score_update_engine.sv
design/pse_checker.sv
tb/perceptron_score_update_engine_tb.sv
